@@ hdl/kea_pkg.sv @@
// Package for the key edge and auto-repeat block: item types, key store entry and constants.
// No dependencies; used by key_edge_and_autorepeat.
package kea_pkg;

	localparam int KEY_COUNT = 256;
	localparam int KEY_AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	localparam logic [15:0] INTERVAL_RESET = 16'd150;

	typedef struct packed {
		logic [7:0]  key_index;
		logic [7:0]  key_value;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0] trigger_bits;
		logic [7:0] release_bits;
		logic [7:0] repeat_bits;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  prev_value;
		logic        armed;
		logic [31:0] last_repeat_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY_RESET = '{prev_value: 8'd0, armed: 1'b1, last_repeat_time: 32'd0};

endpackage

@@ hdl/key_edge_and_autorepeat.sv @@
// Top level of the key edge detector with auto-repeat: per-key store, update stage, output item.
// Depends on kea_pkg and kea_ram.
//
// One item a cycle is accepted unless the output stalls, with one result for each, via
// the update stage and output register. Per-key state (last byte, armed flag, last repeat
// time) sits in one RAM with a registered read: the read is issued as an item is accepted
// and the entry is updated and written back as the item leaves that stage; a sample of
// the same key accepted as that entry is written takes it by forwarding, so back-to-back
// samples of one key cost nothing extra. A flag per key, cleared by reset, marks entries
// never written; such a key reads as last byte zero and armed, so there is no clearing
// pass after reset. The repeat interval may be rewritten only while the block is idle.
module key_edge_and_autorepeat (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kea_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output kea_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);

	import kea_pkg::*;

	logic              acc;
	logic              s1_adv;
	logic [KEY_AW-1:0] rd_addr;
	logic              rd_inrange;

	logic              valid_s1;
	in_item_t          item_s1;
	logic              inrange_s1;
	logic              hit_s1;
	entry_t            fwd_s1;
	logic              seen_s1;

	logic [ENTRY_W-1:0] rdata;
	entry_t            cur;
	entry_t            nxt;
	logic [7:0]        diff;
	logic [31:0]       elapsed;
	logic              fire;
	out_item_t         res;

	logic              wr_en;
	logic [KEY_AW-1:0] wr_addr;

	logic [KEY_COUNT-1:0] written_q;
	logic [15:0]       interval_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	assign acc        = in_valid && in_ready;
	assign s1_adv     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || s1_adv;
	assign rd_addr    = KEY_AW'(in_item.key_index);
	assign rd_inrange = 32'(in_item.key_index) < KEY_COUNT;

	kea_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(KEY_COUNT)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(nxt),
		.re   (acc),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1    <= in_item;
			inrange_s1 <= rd_inrange;
			hit_s1     <= wr_en && (wr_addr == rd_addr);
			fwd_s1     <= nxt;
			seen_s1    <= written_q[rd_addr];
		end
	end

	// pick forwarded, stored or reset entry
	always_comb begin
		if (hit_s1) begin
			cur = fwd_s1;
		end else if (seen_s1) begin
			cur = entry_t'(rdata);
		end else begin
			cur = ENTRY_RESET;
		end
	end

	assign diff    = cur.prev_value ^ item_s1.key_value;
	assign elapsed = item_s1.now_ms - cur.last_repeat_time;
	assign fire    = (item_s1.key_value != 8'd0) && (cur.armed || (elapsed > 32'(interval_q)));

	always_comb begin
		nxt.prev_value       = item_s1.key_value;
		nxt.armed            = cur.armed && !fire;
		nxt.last_repeat_time = fire ? item_s1.now_ms : cur.last_repeat_time;
		if (inrange_s1) begin
			res.trigger_bits = diff & item_s1.key_value;
			res.release_bits = diff & ~item_s1.key_value;
			res.repeat_bits  = fire ? item_s1.key_value : 8'd0;
		end else begin
			res = '0;
		end
	end

	assign wr_en   = s1_adv && inrange_s1;
	assign wr_addr = KEY_AW'(item_s1.key_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(item_s1))
		else $error("update stage lost its item while stalled");

	a_fwd_taken: assert property (@(posedge clk) disable iff (!arst_n)
		acc && wr_en && (wr_addr == rd_addr) |=> hit_s1)
		else $error("same-key item missed the forwarded entry");

	a_repeat_value: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && inrange_s1 && fire |-> item_s1.key_value != 8'd0 && !nxt.armed)
		else $error("repeat fired on a released key or left it armed");

	a_written_mark: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> written_q[$past(wr_addr)])
		else $error("written key not marked");

endmodule

@@ hdl/kea_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module kea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
